FILE: sv/hash_bucket_slot_table_assert.svh
// assertion macros shared by the hash bucket slot table rtl
`ifndef HASH_BUCKET_SLOT_TABLE_ASSERT_SVH
`define HASH_BUCKET_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HBST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbst: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HBST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbst: next-cycle check failed");

`endif

FILE: sv/hbst_pkg.sv
// shared constants and codes for the hash bucket slot table
`timescale 1ns / 1ps

package hbst_pkg;

    // default sizing
    localparam int SLOTS_DEF      = 32;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port field widths
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    // operation codes
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FN_LOOKUP = 2'd0;
    localparam t_func FN_INSERT = 2'd1;
    localparam t_func FN_REMOVE = 2'd2;
    localparam t_func FN_READ   = 2'd3;

endpackage

FILE: sv/hbst_if.sv
// request and result channels of the hash bucket slot table
`timescale 1ns / 1ps

interface hbst_req_if;
    logic                        valid;
    logic                        ready;
    logic [hbst_pkg::FUNC_W-1:0]  func;
    logic [hbst_pkg::KEY_W-1:0]   key;
    logic [hbst_pkg::VALUE_W-1:0] value;
    logic [hbst_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, func, key, value, slot, input ready);
    modport sink   (input valid, func, key, value, slot, output ready);
endinterface

interface hbst_res_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [hbst_pkg::KEY_W-1:0]   out_key;
    logic [hbst_pkg::VALUE_W-1:0] out_value;
    logic                         last;
    logic [hbst_pkg::COUNT_W-1:0] valid_count;
    logic                         full_res;
    logic                         empty_res;

    modport source (output valid, ok, out_key, out_value, last, valid_count,
                    full_res, empty_res, input ready);
    modport sink   (input valid, ok, out_key, out_value, last, valid_count,
                    full_res, empty_res, output ready);
endinterface

FILE: sv/hbst_cell.sv
// one slot of the rotating ring: valid bit, key and value
`timescale 1ns / 1ps

module hbst_cell #(
    parameter int KEY_BITS   = hbst_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = hbst_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_valid,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);
    import hbst_pkg::*;

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // valid bit, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // slot payload, taken from the neighbor on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

FILE: sv/hash_bucket_slot_table.sv
// Hash bucket slot table: SLOTS key/value slots held in a ring of cells that
// rotates by one slot per cycle, while an operation walks it and is not
// stalled, past a single compare point at cell 0. Every operation walks the
// ring and then loads its final word into the output register. Lookup,
// remove, read slot and a refused insert walk it once; an insert that stores
// makes a second turn to reach the lowest free slot before its final word is
// loaded. The next request can be taken in the cycle after the final word is
// loaded. A lookup with several hits emits one word per hit, in slot order,
// as the ring brings up the next hit. When such a hit meets a stalled output
// the ring stops, and a final word that meets a stalled output waits. Either
// way the operation is held up for as long as the stall lasts. A request is
// taken only when no operation is in flight. Valid bits clear at reset; keys
// and values of slots never written read back as undefined.
`timescale 1ns / 1ps

module hash_bucket_slot_table #(
    parameter int SLOTS      = hbst_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = hbst_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = hbst_pkg::VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbst_req_if.sink  i_req,
    hbst_res_if.source o_res
);
    import hbst_pkg::*;

    `include "hash_bucket_slot_table_assert.svh"

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RNG_W = SLOT_W + 2;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SLOTS);

    // controller states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    // ring of cells
    logic                  w_valid [SLOTS];
    logic [KEY_BITS-1:0]   w_key   [SLOTS];
    logic [VALUE_BITS-1:0] w_value [SLOTS];
    logic                  w_adv;
    logic                  w_wb_valid;
    logic [KEY_BITS-1:0]   w_wb_key;
    logic [VALUE_BITS-1:0] w_wb_value;

    // control registers
    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_step, n_step;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;

    // operation registers
    t_func                 r_func, n_func;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_rd_in, n_rd_in;
    logic                  r_dup, n_dup;
    logic                  r_free_found, n_free_found;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_done, n_done;
    logic                  r_pend, n_pend;
    logic [VALUE_BITS-1:0] r_pend_val, n_pend_val;
    logic                  r_rd_ok, n_rd_ok;
    logic [KEY_BITS-1:0]   r_rd_key, n_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val, n_rd_val;

    // output word registers
    logic                  r_out_ok, n_out_ok;
    logic [KEY_W-1:0]      r_out_key, n_out_key;
    logic [VALUE_W-1:0]    r_out_val, n_out_val;
    logic                  r_out_last, n_out_last;
    logic [COUNT_W-1:0]    r_out_cnt, n_out_cnt;
    logic                  r_out_full, n_out_full;
    logic                  r_out_empty, n_out_empty;

    // width adaptation between port fields and stored widths
    logic [63:0]           w_in_key64, w_in_val64;
    logic [63:0]           w_key64, w_pend64, w_rd_key64, w_rd_val64;
    logic                  w_key_hit, w_exact, w_out_free, w_last_step;
    logic [IDX_W-1:0]      w_step_inc;

    assign w_in_key64 = 64'(i_req.key);
    assign w_in_val64 = 64'(i_req.value);
    assign w_key64    = 64'(r_key);
    assign w_pend64   = 64'(r_pend_val);
    assign w_rd_key64 = 64'(r_rd_key);
    assign w_rd_val64 = 64'(r_rd_val);

    // ring: cell i takes from cell i+1, the last cell takes the edited head
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == SLOTS - 1) begin : g_tail
            hbst_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_adv),
                .i_valid (w_wb_valid),
                .i_key   (w_wb_key),
                .i_value (w_wb_value),
                .o_valid (w_valid[g]),
                .o_key   (w_key[g]),
                .o_value (w_value[g])
            );
        end else begin : g_body
            hbst_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_adv),
                .i_valid (w_valid[g+1]),
                .i_key   (w_key[g+1]),
                .i_value (w_value[g+1]),
                .o_valid (w_valid[g]),
                .o_key   (w_key[g]),
                .o_value (w_value[g])
            );
        end
    end

    // compare at the head cell
    assign w_key_hit   = w_valid[0] && (w_key[0] == r_key);
    assign w_exact     = w_key_hit && (w_value[0] == r_value);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_last_step = (r_step == LAST_STEP);
    assign w_step_inc  = w_last_step ? '0 : r_step + 1'b1;

    // sequencer for one operation: its walks of the ring and its final word
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_func       = r_func;
        n_key        = r_key;
        n_value      = r_value;
        n_rd_idx     = r_rd_idx;
        n_rd_in      = r_rd_in;
        n_dup        = r_dup;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_done       = r_done;
        n_pend       = r_pend;
        n_pend_val   = r_pend_val;
        n_rd_ok      = r_rd_ok;
        n_rd_key     = r_rd_key;
        n_rd_val     = r_rd_val;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_ok     = r_out_ok;
        n_out_key    = r_out_key;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_cnt    = r_out_cnt;
        n_out_full   = r_out_full;
        n_out_empty  = r_out_empty;
        w_adv        = 1'b0;
        w_wb_valid   = w_valid[0];
        w_wb_key     = w_key[0];
        w_wb_value   = w_value[0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state      = ST_PASS1;
                    n_func       = i_req.func;
                    n_key        = w_in_key64[KEY_BITS-1:0];
                    n_value      = w_in_val64[VALUE_BITS-1:0];
                    n_rd_idx     = IDX_W'(i_req.slot);
                    n_rd_in      = (RNG_W'(i_req.slot) < RNG_W'(SLOTS));
                    n_dup        = 1'b0;
                    n_free_found = 1'b0;
                    n_done       = 1'b0;
                    n_pend       = 1'b0;
                    n_rd_ok      = 1'b0;
                end
            end
            ST_PASS1: begin
                w_adv = 1'b1;
                unique case (r_func)
                    FN_LOOKUP: begin
                        if (w_key_hit) begin
                            if (r_pend) begin
                                // earlier hit goes out, this one waits
                                if (w_out_free) begin
                                    n_out_valid = 1'b1;
                                    n_out_ok    = 1'b1;
                                    n_out_key   = w_key64[KEY_W-1:0];
                                    n_out_val   = w_pend64[VALUE_W-1:0];
                                    n_out_last  = 1'b0;
                                    n_out_cnt   = COUNT_W'(r_count);
                                    n_out_full  = (r_count == CNT_FULL);
                                    n_out_empty = (r_count == '0);
                                    n_pend_val  = w_value[0];
                                end else begin
                                    w_adv = 1'b0;
                                end
                            end else begin
                                n_pend     = 1'b1;
                                n_pend_val = w_value[0];
                            end
                        end
                    end
                    FN_INSERT: begin
                        if (w_exact) begin
                            n_dup = 1'b1;
                        end
                        if (!w_valid[0] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_step;
                        end
                    end
                    FN_REMOVE: begin
                        if (w_exact && !r_done) begin
                            w_wb_valid = 1'b0;
                            n_done     = 1'b1;
                            n_count    = r_count - 1'b1;
                        end
                    end
                    FN_READ: begin
                        if (r_step == r_rd_idx) begin
                            n_rd_ok  = w_valid[0];
                            n_rd_key = w_key[0];
                            n_rd_val = w_value[0];
                        end
                    end
                    default: ;
                endcase
                if (w_adv) begin
                    n_step = w_step_inc;
                    if (w_last_step) begin
                        if (r_func == FN_INSERT && !n_dup && n_free_found) begin
                            n_state = ST_PASS2;
                        end else begin
                            n_state = ST_FINAL;
                        end
                    end
                end
            end
            ST_PASS2: begin
                // second turn stores the pair in the lowest free slot
                w_adv = 1'b1;
                if (r_step == r_free_idx) begin
                    w_wb_valid = 1'b1;
                    w_wb_key   = r_key;
                    w_wb_value = r_value;
                    n_done     = 1'b1;
                    n_count    = r_count + 1'b1;
                end
                n_step = w_step_inc;
                if (w_last_step) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_key   = w_key64[KEY_W-1:0];
                    n_out_val   = '0;
                    n_out_cnt   = COUNT_W'(r_count);
                    n_out_full  = (r_count == CNT_FULL);
                    n_out_empty = (r_count == '0);
                    unique case (r_func)
                        FN_LOOKUP: begin
                            n_out_ok  = r_pend;
                            n_out_val = r_pend ? w_pend64[VALUE_W-1:0] : '0;
                        end
                        FN_INSERT, FN_REMOVE: begin
                            n_out_ok = r_done;
                        end
                        FN_READ: begin
                            n_out_ok  = r_rd_in && r_rd_ok;
                            n_out_key = r_rd_in ? w_rd_key64[KEY_W-1:0] : '0;
                            n_out_val = r_rd_in ? w_rd_val64[VALUE_W-1:0] : '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // operation and output word payload
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_value      <= n_value;
        r_rd_idx     <= n_rd_idx;
        r_rd_in      <= n_rd_in;
        r_dup        <= n_dup;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_done       <= n_done;
        r_pend       <= n_pend;
        r_pend_val   <= n_pend_val;
        r_rd_ok      <= n_rd_ok;
        r_rd_key     <= n_rd_key;
        r_rd_val     <= n_rd_val;
        r_out_ok     <= n_out_ok;
        r_out_key    <= n_out_key;
        r_out_val    <= n_out_val;
        r_out_last   <= n_out_last;
        r_out_cnt    <= n_out_cnt;
        r_out_full   <= n_out_full;
        r_out_empty  <= n_out_empty;
    end

    // ports
    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.ok          = r_out_ok;
    assign o_res.out_key     = r_out_key;
    assign o_res.out_value   = r_out_val;
    assign o_res.last        = r_out_last;
    assign o_res.valid_count = r_out_cnt;
    assign o_res.full_res    = r_out_full;
    assign o_res.empty_res   = r_out_empty;

    // checks
    `HBST_ASSERT_IMP(a_idle_aligned, i_clk, i_rst_n, r_state == ST_IDLE, r_step == '0)
    `HBST_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `HBST_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == ST_PASS1)
    `HBST_ASSERT_IMP(a_full_empty, i_clk, i_rst_n, r_out_valid, !(r_out_full && r_out_empty))

endmodule

FILE: tb/hash_bucket_slot_table_checker.sv
// result checker for the hash bucket slot table: bucket predictor and word compare
`timescale 1ns / 1ps

module hash_bucket_slot_table_checker #(
    parameter int SLOTS = hbst_pkg::SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hbst_req_if  i_req,
    hbst_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import hbst_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_bucket_word;

    // predicted bucket contents
    logic [SLOTS-1:0]   slot_live;
    logic [KEY_W-1:0]   slot_key [SLOTS];
    logic [VALUE_W-1:0] slot_val [SLOTS];

    // result words still owed by the block, oldest first
    t_bucket_word owed_words [$];
    t_bucket_word want;
    int           mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // queue one result word, status taken from the bucket after the operation
    function automatic void owe_word(logic ok, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] value, logic last);
        t_bucket_word w;
        int           live;
        live    = $countones(slot_live);
        w.ok    = ok;
        w.key   = key;
        w.value = value;
        w.last  = last;
        w.count = COUNT_W'(live);
        w.full  = (live == SLOTS);
        w.empty = (live == 0);
        owed_words = {owed_words, w};
    endfunction

    // apply one request to the predicted bucket and queue its result words
    function automatic void apply_bucket_op(t_func fn, logic [KEY_W-1:0] key,
                                            logic [VALUE_W-1:0] value,
                                            logic [SLOT_W-1:0] slot);
        int   last_hit;
        logic hit;
        logic done;
        last_hit = -1;
        hit      = 1'b0;
        done     = 1'b0;
        case (fn)
            FN_LOOKUP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i] && slot_key[i] == key) last_hit = i;
                end
                if (last_hit < 0) begin
                    owe_word(1'b0, key, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_live[i] && slot_key[i] == key)
                            owe_word(1'b1, key, slot_val[i], i == last_hit);
                    end
                end
            end
            FN_INSERT: begin
                // exact duplicates are refused before looking for room
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i] && slot_key[i] == key && slot_val[i] == value)
                        hit = 1'b1;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && !done && !slot_live[i]) begin
                        slot_live[i] = 1'b1;
                        slot_key[i]  = key;
                        slot_val[i]  = value;
                        done         = 1'b1;
                    end
                end
                owe_word(done, key, '0, 1'b1);
            end
            FN_REMOVE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && slot_live[i] && slot_key[i] == key &&
                        slot_val[i] == value) begin
                        slot_live[i] = 1'b0;
                        done         = 1'b1;
                    end
                end
                owe_word(done, key, '0, 1'b1);
            end
            default: begin
                if (int'(slot) >= SLOTS)
                    owe_word(1'b0, '0, '0, 1'b1);
                else
                    owe_word(slot_live[slot], slot_key[slot], slot_val[slot], 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_total++;
        end
    endfunction

    // watch both channels: compare finished words, predict accepted requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_live = '0;
            owed_words.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (owed_words.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    mismatch_total++;
                end else begin
                    want = owed_words.pop_front();
                    check_field("ok", 32'(want.ok), 32'(i_res.ok));
                    check_field("out_key", want.key, i_res.out_key);
                    check_field("out_value", want.value, i_res.out_value);
                    check_field("last", 32'(want.last), 32'(i_res.last));
                    check_field("valid_count", 32'(want.count), 32'(i_res.valid_count));
                    check_field("full_res", 32'(want.full), 32'(i_res.full_res));
                    check_field("empty_res", 32'(want.empty), 32'(i_res.empty_res));
                end
            end
            if (i_req.valid && i_req.ready)
                apply_bucket_op(i_req.func, i_req.key, i_req.value, i_req.slot);
        end
        o_pending <= owed_words.size();
    end

endmodule

FILE: tb/hash_bucket_slot_table_test.sv
// top of the hash bucket slot table test: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module hash_bucket_slot_table_test;
    import hbst_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 12;
    localparam int HOLD_AT       = 55;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ROUNDS        = 2;
    localparam int MIXED_OPS     = 24;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_kv_pair;

    logic i_clk;
    logic i_rst_n;

    hbst_req_if req_ch ();
    hbst_res_if res_ch ();

    int fail_count;
    int pending;
    int cycles;
    int sent_total;
    int op_seen [4];
    bit calm;
    bit hold_done;

    logic [KEY_W-1:0] key_pool [4];
    int               pool_size;
    t_kv_pair         placed_pairs [$];

    hash_bucket_slot_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    hash_bucket_slot_table_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
        $display("FAIL hash_bucket_slot_table");
        $finish;
    end

    // result side: random stalls, one long hold-off once traffic is under way
    initial begin
        res_ch.ready <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_total >= HOLD_AT) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one request word, with random gaps ahead of it
    task automatic send_op(t_func fn, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                           logic [SLOT_W-1:0] slot);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= fn;
        req_ch.key   <= key;
        req_ch.value <= value;
        req_ch.slot  <= slot;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_total++;
        op_seen[fn]++;
    endtask

    // stop offering and wait for every owed word
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one random operation over a mostly populated bucket
    task automatic mixed_op();
        int                 pick;
        int                 idx;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        t_kv_pair           p;
        pick = $urandom_range(99);
        k    = ($urandom_range(1) == 1) ? key_pool[$urandom_range(pool_size - 1)] : $urandom;
        v    = $urandom;
        if (pick < 30) begin
            send_op(FN_LOOKUP, k, v, SLOT_W'($urandom));
        end else if (pick < 55) begin
            // sometimes repeat a stored pair to hit the duplicate refusal
            if (placed_pairs.size() > 0 && $urandom_range(3) == 0) begin
                p = placed_pairs[$urandom_range(placed_pairs.size() - 1)];
                k = p.key;
                v = p.value;
            end
            send_op(FN_INSERT, k, v, SLOT_W'($urandom));
            p.key   = k;
            p.value = v;
            placed_pairs = {placed_pairs, p};
        end else if (pick < 80) begin
            if (placed_pairs.size() > 0 && $urandom_range(3) != 0) begin
                idx = $urandom_range(placed_pairs.size() - 1);
                p   = placed_pairs[idx];
                placed_pairs.delete(idx);
                k = p.key;
                v = p.value;
            end
            send_op(FN_REMOVE, k, v, SLOT_W'($urandom));
        end else begin
            send_op(FN_READ, k, v, SLOT_W'($urandom_range(31)));
        end
    endtask

    // stimulus and verdict
    initial begin
        t_kv_pair p;
        int       idx;
        logic [VALUE_W-1:0] v;

        req_ch.valid <= 1'b0;
        req_ch.func  <= FN_LOOKUP;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        req_ch.slot  <= '0;
        i_rst_n      <= 1'b0;
        calm       = 1'b0;
        sent_total = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty bucket, duplicates, multi-hit lookup, extreme keys and values
        send_op(FN_LOOKUP, 32'h0000_1234, 32'h0, 5'd0);
        send_op(FN_REMOVE, 32'h0000_1234, 32'h1, 5'd31);
        send_op(FN_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
        send_op(FN_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
        send_op(FN_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
        send_op(FN_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 5'd0);
        send_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 5'd0);
        send_op(FN_LOOKUP, 32'h0000_0000, 32'h0, 5'd0);
        send_op(FN_READ, 32'h0, 32'h0, 5'd0);
        send_op(FN_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2);
        send_op(FN_REMOVE, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 5'd0);
        send_op(FN_REMOVE, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 5'd0);
        // a cleared slot still returns what it holds
        send_op(FN_READ, 32'h0, 32'h0, 5'd2);
        send_op(FN_REMOVE, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_op(FN_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 5'd0);
        send_op(FN_LOOKUP, 32'h1234_5679, 32'h0, 5'd0);
        send_op(FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
        send_op(FN_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
        send_op(FN_REMOVE, 32'h1234_5678, 32'h9ABC_DEF0, 5'd0);
        send_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 5'd0);
        send_op(FN_READ, 32'h0, 32'h0, 5'd1);
        wait_drained();

        // random rounds: fill to capacity, probe, mix, then drain to empty
        for (int r = 0; r < ROUNDS; r++) begin
            pool_size = (r == 0) ? 1 : 4;
            foreach (key_pool[i]) key_pool[i] = $urandom;
            calm = (r == 1);

            // unique values, so the last insert finds the bucket full
            for (int n = 0; n <= 32; n++) begin
                v = ($urandom & ~32'h3F) | VALUE_W'(n);
                p.key   = key_pool[$urandom_range(pool_size - 1)];
                p.value = v;
                send_op(FN_INSERT, p.key, p.value, SLOT_W'($urandom));
                if (n < 32) placed_pairs = {placed_pairs, p};
            end
            calm = 1'b0;

            for (int i = 0; i < pool_size; i++)
                send_op(FN_LOOKUP, key_pool[i], $urandom, SLOT_W'($urandom));
            send_op(FN_LOOKUP, $urandom, $urandom, SLOT_W'($urandom));
            repeat (4) send_op(FN_READ, $urandom, $urandom, SLOT_W'($urandom_range(31)));

            repeat (MIXED_OPS) mixed_op();
            if (r == 0) wait_drained();

            while (placed_pairs.size() > 0) begin
                idx = $urandom_range(placed_pairs.size() - 1);
                p   = placed_pairs[idx];
                placed_pairs.delete(idx);
                send_op(FN_REMOVE, p.key, p.value, SLOT_W'($urandom));
            end
        end
        send_op(FN_LOOKUP, key_pool[0], 32'h0, 5'd31);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d lookups, %0d inserts, %0d removes, %0d slot reads",
                 sent_total, op_seen[FN_LOOKUP], op_seen[FN_INSERT], op_seen[FN_REMOVE],
                 op_seen[FN_READ]);
        $display("bucket filled twice, once all under one key; result hold %0d cycles",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS hash_bucket_slot_table");
        end else begin
            $display("FAIL hash_bucket_slot_table");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/hbst_pkg.sv
sv/hbst_if.sv
sv/hbst_cell.sv
sv/hash_bucket_slot_table.sv
tb/hash_bucket_slot_table_checker.sv
tb/hash_bucket_slot_table_test.sv
